@@ hdl/hcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the huffman code bit packer: input mode
// codes, queue entry layout and queue status.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // field widths fixed by the item format
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int SYM_W    = 8;
  localparam int MODE_W   = 2;

  // queue between front and back
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  // input mode codes
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_LOAD   = 2'd0;
  localparam mode_t MODE_ENCODE = 2'd1;
  localparam mode_t MODE_FLUSH  = 2'd2;

  // work kinds handed to the back end
  typedef enum logic {
    OP_ENCODE,
    OP_FLUSH
  } op_kind_t;

  // one queued job
  typedef struct packed {
    op_kind_t              kind;
    logic [CODE_W-1:0]     code;
    logic [LEN_W-1:0]      len;
  } q_entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic [QCNT_W-1:0]     count;
    logic                  not_empty;
  } q_status_t;

endpackage

@@ hdl/hcbp_if.sv @@
// ----------------------------------------------------------------------------
// hcbp channel interfaces
// Valid/ready channels for input items and for packed result bytes.
// ----------------------------------------------------------------------------
interface hcbp_in_if import hcbp_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [SYM_W-1:0]    symbol;
  logic [CODE_W-1:0]   code_bits;
  logic [LEN_W-1:0]    code_length;

  modport source (output valid, mode, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, mode, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_out_if;
  logic                valid;
  logic                ready;
  logic [7:0]          out_byte;
  logic                byte_valid;
  logic [2:0]          pad_bits;
  logic                last;

  modport source (output valid, out_byte, byte_valid, pad_bits, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, pad_bits, last, output ready);
endinterface

@@ hdl/hcbp_ram.sv @@
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/hcbp_queue.sv @@
// ----------------------------------------------------------------------------
// hcbp_queue
// Short job queue between the classifying front end and the packing back end.
// ----------------------------------------------------------------------------
module hcbp_queue import hcbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_pop;

  assign do_pop = pop && (count_r != '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head             = mem_r[rd_ptr_r];
  assign status.count     = count_r;
  assign status.not_empty = (count_r != '0);

endmodule

@@ hdl/hcbp_front.sv @@
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts input transactions, writes code table loads, looks up encode
// symbols and queues encode and flush jobs in arrival order.
// ----------------------------------------------------------------------------
module hcbp_front import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  hcbp_in_if.sink    in_ch,
  input  q_status_t  q_status,
  output logic       push,
  output q_entry_t   push_entry
);

  localparam int AW        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int OCC_W     = QCNT_W + 1;

  logic [OCC_W-1:0]  occupied;
  logic              accept;
  logic              in_range;
  logic              is_load, is_enc, is_flush;
  logic [LEN_W-1:0]  ld_len;
  logic [CODE_W-1:0] ld_code;
  logic [AW-1:0]     addr;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic              s1_valid_r;
  op_kind_t          s1_kind_r;

  // room check counts the job still waiting on the table read
  assign occupied    = OCC_W'(q_status.count) + OCC_W'(s1_valid_r);
  assign in_ch.ready = (occupied < OCC_W'(QDEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  // classify the transaction
  assign in_range = ({1'b0, in_ch.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign is_load  = accept && (in_ch.mode == MODE_LOAD) && in_range;
  assign is_enc   = accept && (in_ch.mode == MODE_ENCODE) && in_range;
  assign is_flush = accept && (in_ch.mode == MODE_FLUSH);
  assign addr     = in_ch.symbol[AW-1:0];

  // clamp length and drop code bits above it
  assign ld_len  = ({1'b0, in_ch.code_length} > (LEN_W + 1)'(LEN_LIMIT)) ?
                   LEN_W'(LEN_LIMIT) : in_ch.code_length;
  assign ld_code = in_ch.code_bits & ~({CODE_W{1'b1}} << ld_len);

  // code and length tables
  hcbp_ram #(.WIDTH(CODE_W), .DEPTH(SYMBOL_COUNT)) u_code_ram (
    .clk   (clk),
    .we    (is_load),
    .waddr (addr),
    .wdata (ld_code),
    .re    (is_enc),
    .raddr (addr),
    .rdata (rd_code)
  );

  hcbp_ram #(.WIDTH(LEN_W), .DEPTH(SYMBOL_COUNT)) u_len_ram (
    .clk   (clk),
    .we    (is_load),
    .waddr (addr),
    .wdata (ld_len),
    .re    (is_enc),
    .raddr (addr),
    .rdata (rd_len)
  );

  // lookup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= is_enc || is_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (is_enc || is_flush) begin
      s1_kind_r <= is_flush ? OP_FLUSH : OP_ENCODE;
    end
  end

  // queue write once the table data is back
  assign push            = s1_valid_r;
  assign push_entry.kind = s1_kind_r;
  assign push_entry.code = rd_code;
  assign push_entry.len  = rd_len;

endmodule

@@ hdl/hcbp_back.sv @@
// ----------------------------------------------------------------------------
// hcbp_back
// Byte packer: takes queued jobs, merges code bits into the MSB-first
// accumulator one byte per cycle while the result register is free, and drives the result register.
// ----------------------------------------------------------------------------
module hcbp_back import hcbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_entry_t   head,
  input  q_status_t  q_status,
  output logic       pop,
  hcbp_out_if.source out_ch
);

  logic              busy_r, busy_nxt;
  op_kind_t          cur_kind_r, cur_kind_nxt;
  logic [CODE_W-1:0] cur_code_r, cur_code_nxt;
  logic [LEN_W-1:0]  cur_rem_r, cur_rem_nxt;
  logic [7:0]        partial_r, partial_nxt;
  logic [2:0]        filled_r, filled_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              byte_valid_r, byte_valid_nxt;
  logic [2:0]        pad_bits_r, pad_bits_nxt;
  logic              last_r, last_nxt;

  logic              slot_free;
  logic [3:0]        need;
  logic              rem_ge;
  logic [LEN_W-1:0]  shift_amt;
  logic [CODE_W-1:0] shifted;
  logic [7:0]        take;
  logic [7:0]        rem_mask;
  logic [7:0]        ins;

  assign slot_free = !out_valid_r || out_ch.ready;

  // bits still missing from the current byte and the slice that fills it
  assign need      = 4'd8 - {1'b0, filled_r};
  assign rem_ge    = (cur_rem_r >= LEN_W'(need));
  assign shift_amt = cur_rem_r - LEN_W'(need);
  assign shifted   = cur_code_r >> shift_amt;
  assign take      = shifted[7:0] & ~(8'hFF << need);

  // leftover bits that do not complete a byte, placed below the filled ones
  assign rem_mask  = ~(8'hFF << cur_rem_r[3:0]);
  assign ins       = (cur_code_r[7:0] & rem_mask) << (need - cur_rem_r[3:0]);

  // job sequencing and accumulator update
  always_comb begin
    busy_nxt       = busy_r;
    cur_kind_nxt   = cur_kind_r;
    cur_code_nxt   = cur_code_r;
    cur_rem_nxt    = cur_rem_r;
    partial_nxt    = partial_r;
    filled_nxt     = filled_r;
    pop            = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_byte_nxt   = out_byte_r;
    byte_valid_nxt = byte_valid_r;
    pad_bits_nxt   = pad_bits_r;
    last_nxt       = last_r;

    if (!busy_r) begin
      if (q_status.not_empty) begin
        pop          = 1'b1;
        busy_nxt     = 1'b1;
        cur_kind_nxt = head.kind;
        cur_code_nxt = head.code;
        cur_rem_nxt  = head.len;
      end
    end else begin
      case (cur_kind_r)
        OP_FLUSH: begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = partial_r;
            byte_valid_nxt = (filled_r != 3'd0);
            pad_bits_nxt   = (filled_r != 3'd0) ? need[2:0] : 3'd0;
            last_nxt       = 1'b1;
            partial_nxt    = 8'd0;
            filled_nxt     = 3'd0;
            busy_nxt       = 1'b0;
          end
        end
        OP_ENCODE: begin
          if (cur_rem_r == '0) begin
            busy_nxt = 1'b0;
          end else if (rem_ge) begin
            // a byte completes
            if (slot_free) begin
              out_valid_nxt  = 1'b1;
              out_byte_nxt   = partial_r | take;
              byte_valid_nxt = 1'b1;
              pad_bits_nxt   = 3'd0;
              last_nxt       = (shift_amt < LEN_W'(8));
              partial_nxt    = 8'd0;
              filled_nxt     = 3'd0;
              cur_rem_nxt    = shift_amt;
              busy_nxt       = (shift_amt != '0);
            end
          end else begin
            // tail bits stay in the accumulator
            partial_nxt = partial_r | ins;
            filled_nxt  = filled_r + cur_rem_r[2:0];
            cur_rem_nxt = '0;
            busy_nxt    = 1'b0;
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  // control and accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      partial_r   <= 8'd0;
      filled_r    <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      partial_r   <= partial_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // job and result payload
  always_ff @(posedge clk) begin
    cur_kind_r   <= cur_kind_nxt;
    cur_code_r   <= cur_code_nxt;
    cur_rem_r    <= cur_rem_nxt;
    out_byte_r   <= out_byte_nxt;
    byte_valid_r <= byte_valid_nxt;
    pad_bits_r   <= pad_bits_nxt;
    last_r       <= last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.byte_valid = byte_valid_r;
  assign out_ch.pad_bits   = pad_bits_r;
  assign out_ch.last       = last_r;

endmodule

@@ hdl/huffman_code_bit_packer_unit.sv @@
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// MSB-first variable-length code packer with a loadable code table.
// ----------------------------------------------------------------------------
// A load transaction writes the table in the cycle it is accepted. Encode and
// flush transactions are looked up and placed in a four-deep job queue, so
// the input keeps accepting while the packer works. The packer settles the
// throughput: an encode job is started, then emits each completed byte once
// the output register is free and keeps any leftover bits in the accumulator;
// a flush job is started and then emits its result. A result waiting in the
// output register never blocks the input side until the job queue is full.
module huffman_code_bit_packer_unit import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  hcbp_in_if.sink    in_ch,
  hcbp_out_if.source out_ch
);

  logic      push;
  q_entry_t  push_entry;
  logic      pop;
  q_entry_t  head;
  q_status_t q_status;

  // intake, table and lookup
  hcbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // job queue
  hcbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // byte packer
  hcbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

@@ hdl/hcbp_checker.sv @@
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks on the packer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hcbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic [2:0] pad_bits,
  input logic       last
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(byte_valid)
       && $stable(pad_bits) && $stable(last)))
    else $error("stalled result changed");

  // empty flush carries zero byte, zero padding and closes the transaction
  a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !byte_valid) |-> (out_byte == 8'd0 && pad_bits == 3'd0 && last))
    else $error("malformed empty flush result");

  // padding only appears on a final flush byte with its unused bits clear
  a_pad_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && pad_bits != 3'd0) |->
      (last && byte_valid && ((out_byte & ~(8'hFF << pad_bits)) == 8'd0)))
    else $error("padding on a non-final byte or dirty pad bits");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .byte_valid (out_ch.byte_valid),
  .pad_bits   (out_ch.pad_bits),
  .last       (out_ch.last)
);
